// ===== design/c2dcb_pkg.sv =====
// ----------------------------------------------------------------------------
// c2dcb_pkg: shared definitions for the clamped-border 2D convolution
// Operation codes, register indexes, field widths and the coefficient cell
// control bundle.
// ----------------------------------------------------------------------------
package c2dcb_pkg;

  // Field widths
  localparam int OP_W      = 2;
  localparam int CIDX_W    = 6;
  localparam int PIX_W     = 16;
  localparam int RES_W     = 24;
  localparam int POS_W     = 10;
  localparam int LANES     = 3;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL     = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH     = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUM_CHANNELS  = 3'd4;

  // Control shared by every coefficient cell
  typedef struct packed {
    logic                     shift;
    logic                     wr_en;
    logic [CIDX_W-1:0]        wr_index;
    logic signed [PIX_W-1:0]  wr_data;
  } cell_ctrl_t;

endpackage

// ===== design/c2dcb_ram.sv =====
// ----------------------------------------------------------------------------
// c2dcb_ram: generic single-port RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module c2dcb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 7168
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ===== design/c2dcb_coef_cell.sv =====
// ----------------------------------------------------------------------------
// c2dcb_coef_cell: one kernel coefficient of the rotating coefficient ring
// Loads its own tap index on a write, passes its value to the neighbor on
// every shift.
// ----------------------------------------------------------------------------
module c2dcb_coef_cell #(
  parameter int INDEX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  c2dcb_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [c2dcb_pkg::PIX_W-1:0]    next_i,
  output logic signed [c2dcb_pkg::PIX_W-1:0]    coef_o
);
  import c2dcb_pkg::*;

  logic                    hit;
  logic signed [PIX_W-1:0] coef_q, coef_d;

  assign hit = (INDEX < (1 << CIDX_W)) && (ctrl_i.wr_index == CIDX_W'(INDEX));

  // shift has priority; writes only come while the ring is parked
  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.shift) begin
      coef_d = next_i;
    end else if (ctrl_i.wr_en && hit) begin
      coef_d = ctrl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== design/conv2d_clamped_border.sv =====
// ----------------------------------------------------------------------------
// conv2d_clamped_border: streaming KxK convolution, replicated borders
// A coefficient load does not stall the input; a pixel holds it through the
// emission check. A flush goes straight to the coefficient ring turn; a pixel
// that emits runs it after the check. The input stalls until the output
// register takes the result: 49-step coefficient ring turn, pipeline drain,
// then the finish state loads the output register.
// Reset clears counters, coefficients and the output register; the line
// store is not cleared.
// ----------------------------------------------------------------------------
module conv2d_clamped_border #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int CHANNELS   = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [c2dcb_pkg::OP_W-1:0]             operation_i,
  input  logic [c2dcb_pkg::CIDX_W-1:0]           coef_index_i,
  input  logic signed [c2dcb_pkg::PIX_W-1:0]     coef_value_i,
  input  logic signed [c2dcb_pkg::PIX_W-1:0]     pixel_ch0_i,
  input  logic signed [c2dcb_pkg::PIX_W-1:0]     pixel_ch1_i,
  input  logic signed [c2dcb_pkg::PIX_W-1:0]     pixel_ch2_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [c2dcb_pkg::RES_W-1:0]     result_ch0_o,
  output logic signed [c2dcb_pkg::RES_W-1:0]     result_ch1_o,
  output logic signed [c2dcb_pkg::RES_W-1:0]     result_ch2_o,
  output logic [c2dcb_pkg::POS_W-1:0]            out_col_o,
  output logic [c2dcb_pkg::POS_W-1:0]            out_row_o,
  output logic                                   frame_end_o,
  input  logic                                   cfg_we_i,
  input  logic [c2dcb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [c2dcb_pkg::CFG_W-1:0]            cfg_data_i
);
  import c2dcb_pkg::*;

  localparam int KTAPS       = MAX_KERNEL * MAX_KERNEL;
  localparam int KW          = $clog2(MAX_KERNEL + 1);
  localparam int TW          = $clog2(KTAPS + 1);
  localparam int STORE_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int LIN_W       = 2 * POS_W;
  localparam int SHIFT       = LIN_W + AW + 1;
  localparam int RECIP_W     = LIN_W + 2;
  localparam int PW          = LIN_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH);
  localparam int WMAX        = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int CMAX        = (CHANNELS < LANES) ? CHANNELS : LANES;
  localparam int DLY_W       = CFG_W + KW + 1;
  localparam int CMP_W       = LIN_W + 3;
  localparam int PROD_W      = 2 * PIX_W;
  localparam int ACC_W       = PROD_W + $clog2(KTAPS) + 1;
  localparam int SUM_W       = ACC_W + 2;
  localparam int STW         = LANES * PIX_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHK, ST_RUN, ST_DRAIN, ST_FIN
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [2:0]       kernel_size_q;
  logic [CFG_W-1:0] image_width_q, image_height_q;
  logic [1:0]       channel_count_q;
  logic             sum_channels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_size_q   <= 3'd3;
      image_width_q   <= 11'd640;
      image_height_q  <= 11'd480;
      channel_count_q <= 2'd3;
      sum_channels_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KERNEL_SIZE:   kernel_size_q   <= cfg_data_i[2:0];
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i;
        CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[1:0];
        CFG_SUM_CHANNELS:  sum_channels_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [KW-1:0]    eff_k, rad, hk;
  logic [CFG_W-1:0] eff_w, eff_h;
  logic [1:0]       eff_c;

  always_comb begin
    if (kernel_size_q == 3'd0)                 eff_k = KW'(1);
    else if (32'(kernel_size_q) > MAX_KERNEL)  eff_k = KW'(MAX_KERNEL);
    else                                       eff_k = KW'(kernel_size_q);
    if (image_width_q == '0)                   eff_w = CFG_W'(1);
    else if (32'(image_width_q) > WMAX)        eff_w = CFG_W'(WMAX);
    else                                       eff_w = image_width_q;
    if (image_height_q == '0)                  eff_h = CFG_W'(1);
    else if (image_height_q > 11'd1024)        eff_h = 11'd1024;
    else                                       eff_h = image_height_q;
    if (channel_count_q == 2'd0)               eff_c = 2'd1;
    else if (32'(channel_count_q) > CMAX)      eff_c = 2'(CMAX);
    else                                       eff_c = channel_count_q;
  end

  assign rad = eff_k >> 1;
  assign hk  = eff_k - KW'(1) - rad;

  // --------------------------------------------------------------------------
  // Control state
  state_e           state_q;
  logic [POS_W-1:0] in_col_q, in_row_q, emit_col_q, emit_row_q;
  logic             input_done_q;
  logic [LIN_W-1:0] lin_in_q;
  logic [DLY_W-1:0] delay_q;
  logic [KW-1:0]    dy_q, dx_q;
  logic [TW-1:0]    tap_q;
  logic             out_valid_q, frame_end_q;
  logic signed [RES_W-1:0] res_q [LANES];
  logic [POS_W-1:0] out_col_q, out_row_q;
  logic             pipe_busy;

  logic accept, is_pixel, run_start, emit_hit, can_out;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_pixel   = accept && (operation_i == OP_PIXEL) && !input_done_q;
  assign can_out    = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Tap coordinates with border clamp
  logic signed [12:0] ys, xs;
  logic [POS_W-1:0]   tap_y, tap_x;

  always_comb begin
    ys = $signed(13'(emit_row_q)) - $signed(13'(rad)) + $signed(13'(dy_q));
    xs = $signed(13'(emit_col_q)) - $signed(13'(rad)) + $signed(13'(dx_q));
    if (ys < 0)                                     tap_y = '0;
    else if (ys > $signed(13'(eff_h)) - 13'sd1)     tap_y = POS_W'(eff_h - 11'd1);
    else                                            tap_y = POS_W'(ys);
    if (xs < 0)                                     tap_x = '0;
    else if (xs > $signed(13'(eff_w)) - 13'sd1)     tap_x = POS_W'(eff_w - 11'd1);
    else                                            tap_x = POS_W'(xs);
  end

  // Shared raster index multiplier: write address or tap address
  logic [POS_W-1:0] mul_row, mul_col;
  logic [LIN_W-1:0] lin_now;

  assign mul_row = (state_q == ST_RUN) ? tap_y : in_row_q;
  assign mul_col = (state_q == ST_RUN) ? tap_x : in_col_q;
  assign lin_now = LIN_W'(LIN_W'(mul_row) * LIN_W'(eff_w)) + LIN_W'(mul_col);

  // Output emission check
  logic [CMP_W-1:0] lin_emit;
  assign lin_emit = CMP_W'(CMP_W'(emit_row_q) * CMP_W'(eff_w)) + CMP_W'(emit_col_q)
                  + CMP_W'(delay_q);
  assign emit_hit  = CMP_W'(lin_in_q) >= lin_emit;
  assign run_start = ((state_q == ST_CHK) && emit_hit)
                  || (accept && (operation_i == OP_FLUSH) && input_done_q);

  // --------------------------------------------------------------------------
  // Coefficient ring
  cell_ctrl_t              cell_ctrl;
  logic signed [PIX_W-1:0] coef [KTAPS];

  assign cell_ctrl.shift    = (state_q == ST_RUN);
  assign cell_ctrl.wr_en    = accept && (operation_i == OP_LOAD_COEF);
  assign cell_ctrl.wr_index = coef_index_i;
  assign cell_ctrl.wr_data  = coef_value_i;

  for (genvar i = 0; i < KTAPS; i++) begin : g_cell
    c2dcb_coef_cell #(.INDEX(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .next_i (coef[(i + 1) % KTAPS]),
      .coef_o (coef[i])
    );
  end

  // --------------------------------------------------------------------------
  // Rounding and saturation to Q12.12
  function automatic logic signed [RES_W-1:0] round_sat(input logic signed [SUM_W-1:0] a);
    logic signed [SUM_W-1:0] v;
    v = (a + SUM_W'(2048)) >>> 12;
    if (v > $signed(SUM_W'(8388607)))        round_sat = 24'sh7FFFFF;
    else if (v < -$signed(SUM_W'(8388608)))  round_sat = 24'sh800000;
    else                                     round_sat = RES_W'(v);
  endfunction

  logic signed [ACC_W-1:0] acc_q [LANES];
  logic signed [SUM_W-1:0] total;
  logic signed [RES_W-1:0] res_d [LANES];

  always_comb begin
    total = '0;
    for (int c = 0; c < LANES; c++) begin
      if (c < 32'(eff_c)) total = total + SUM_W'(acc_q[c]);
    end
    for (int c = 0; c < LANES; c++) begin
      res_d[c] = '0;
      if (sum_channels_q) begin
        if (c == 0) res_d[c] = round_sat(total);
      end else if (c < 32'(eff_c)) begin
        res_d[c] = round_sat(SUM_W'(acc_q[c]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: counters, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_col_q     <= '0;
      in_row_q     <= '0;
      emit_col_q   <= '0;
      emit_row_q   <= '0;
      input_done_q <= 1'b0;
      lin_in_q     <= '0;
      delay_q      <= '0;
      dy_q         <= '0;
      dx_q         <= '0;
      tap_q        <= '0;
      out_valid_q  <= 1'b0;
      frame_end_q  <= 1'b0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      for (int c = 0; c < LANES; c++) res_q[c] <= '0;
    end else begin
      // output register: load on finish, free once taken
      if ((state_q == ST_FIN) && can_out) out_valid_q <= 1'b1;
      else if (!out_stall_i)              out_valid_q <= 1'b0;
      if (run_start) begin
        dy_q  <= '0;
        dx_q  <= '0;
        tap_q <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (is_pixel) begin
            lin_in_q <= lin_now;
            delay_q  <= DLY_W'(DLY_W'(hk) * DLY_W'(eff_w)) + DLY_W'(hk);
            if (12'(in_col_q) + 12'd1 >= 12'(eff_w)) begin
              in_col_q <= '0;
              if (12'(in_row_q) + 12'd1 >= 12'(eff_h)) begin
                input_done_q <= 1'b1;
                in_row_q     <= '0;
              end else begin
                in_row_q <= in_row_q + POS_W'(1);
              end
            end else begin
              in_col_q <= in_col_q + POS_W'(1);
            end
            state_q <= ST_CHK;
          end else if (run_start) begin
            state_q <= ST_RUN;
          end
        end
        ST_CHK: begin
          state_q <= emit_hit ? ST_RUN : ST_IDLE;
        end
        ST_RUN: begin
          if (dy_q < eff_k) begin
            if (dx_q == eff_k - KW'(1)) begin
              dx_q <= '0;
              dy_q <= dy_q + KW'(1);
            end else begin
              dx_q <= dx_q + KW'(1);
            end
          end
          tap_q <= tap_q + TW'(1);
          if (tap_q == TW'(KTAPS - 1)) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!pipe_busy) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (can_out) begin
            for (int c = 0; c < LANES; c++) res_q[c] <= res_d[c];
            out_col_q <= emit_col_q;
            out_row_q <= emit_row_q;
            frame_end_q <= (12'(emit_col_q) + 12'd1 >= 12'(eff_w))
                        && (12'(emit_row_q) + 12'd1 >= 12'(eff_h));
            if (12'(emit_col_q) + 12'd1 >= 12'(eff_w)) begin
              emit_col_q <= '0;
              if (12'(emit_row_q) + 12'd1 >= 12'(eff_h)) begin
                in_col_q     <= '0;
                in_row_q     <= '0;
                emit_row_q   <= '0;
                input_done_q <= 1'b0;
              end else begin
                emit_row_q <= emit_row_q + POS_W'(1);
              end
            end else begin
              emit_col_q <= emit_col_q + POS_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Address, store and multiply-accumulate pipeline
  logic             v1_q, w1_q, v2_q, w2_q, v3_q, w3_q, v4_q, v5_q;
  logic [LIN_W-1:0] lin1_q, lin2_q;
  logic [PW-1:0]    prod2_q;
  logic [AW-1:0]    rem3_q;
  logic [STW-1:0]   pix1_q, pix2_q, pix3_q, rdata;
  logic signed [PIX_W-1:0]  c1_q, c2_q, c3_q, c4_q;
  logic signed [PROD_W-1:0] prod5_q [LANES];
  logic [LIN_W-1:0] qd;

  assign pipe_busy = v1_q || v2_q || v3_q || v4_q || v5_q;
  assign qd = LIN_W'(LIN_W'(prod2_q >> SHIFT) * LIN_W'(STORE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; w1_q <= 1'b0;
      v2_q <= 1'b0; w2_q <= 1'b0;
      v3_q <= 1'b0; w3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0;
    end else begin
      v1_q <= is_pixel || ((state_q == ST_RUN) && (dy_q < eff_k));
      w1_q <= is_pixel;
      v2_q <= v1_q; w2_q <= w1_q;
      v3_q <= v2_q; w3_q <= w2_q;
      v4_q <= v3_q && !w3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lin1_q  <= lin_now;
    pix1_q  <= {pixel_ch2_i, pixel_ch1_i, pixel_ch0_i};
    c1_q    <= coef[0];
    // reciprocal multiply for the modulo by the store depth
    prod2_q <= PW'(lin1_q) * PW'(RECIP);
    lin2_q  <= lin1_q;
    pix2_q  <= pix1_q;
    c2_q    <= c1_q;
    rem3_q  <= AW'(lin2_q - qd);
    pix3_q  <= pix2_q;
    c3_q    <= c2_q;
    c4_q    <= c3_q;
    for (int c = 0; c < LANES; c++) begin
      prod5_q[c] <= PROD_W'(c4_q) * PROD_W'($signed(rdata[c*PIX_W +: PIX_W]));
    end
    for (int c = 0; c < LANES; c++) begin
      if (run_start)  acc_q[c] <= '0;
      else if (v5_q)  acc_q[c] <= acc_q[c] + ACC_W'(prod5_q[c]);
    end
  end

  c2dcb_ram #(.WIDTH(STW), .DEPTH(STORE_DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .en_i    (v3_q),
    .we_i    (w3_q),
    .addr_i  (rem3_q),
    .wdata_i (pix3_q),
    .rdata_o (rdata)
  );

  // --------------------------------------------------------------------------
  // Outputs
  assign out_valid_o  = out_valid_q;
  assign result_ch0_o = res_q[0];
  assign result_ch1_o = res_q[1];
  assign result_ch2_o = res_q[2];
  assign out_col_o    = out_col_q;
  assign out_row_o    = out_row_q;
  assign frame_end_o  = frame_end_q;

endmodule
